FILE: src/tbgl_pkg.sv
// ----------------------------------------------------------------------------
// tbgl_pkg: shared types and codes for the two-button gesture latch
// Command, event and button-state codes, plus the request and result
// records passed between the core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tbgl_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned WINDOW_W = 16;
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned STATE_W  = 3;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

   // commands
   localparam logic [CMD_W-1:0] CMD_EVENT      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EVALUATE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ_LEFT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_RIGHT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_COMBO = 3'd4;

   // event kinds
   localparam logic [KIND_W-1:0] EV_LONG = 3'd4;

   // button selector
   localparam logic BTN_LEFT = 1'b0;

   // button states
   localparam logic [STATE_W-1:0] ST_IDLE    = 3'd0;
   localparam logic [STATE_W-1:0] ST_PENDING = 3'd5;
   localparam logic [STATE_W-1:0] ST_LONG    = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic              which_button;
      logic [KIND_W-1:0] event_kind;
      logic [TIME_W-1:0] time_ms;
   } req_item_type;

   typedef struct packed {
      logic [STATE_W-1:0] button_state;
      logic               combo_state;
   } rsp_item_type;

   typedef struct packed {
      logic left_pending;
      logic right_pending;
      logic combo_flag;
   } core_status_type;

endpackage

`default_nettype wire

FILE: src/two_button_gesture_latch.sv
// ----------------------------------------------------------------------------
// two_button_gesture_latch: latch gestures from two buttons
// Takes one request per cycle when not stalled: a button event, an evaluate
// command or a read, and returns one response per request in order. A request
// is held in an input register, processed against the gesture state when the
// output register is free or draining, and its response lands in the output
// register; the sustained rate is one request per clock while responses are
// taken, set by the state update with its 32-bit elapsed-time
// subtract and compare. The request side keeps accepting while a response
// waits, as long as the input register can drain into the core. The combo
// window register (reset 500 ms) is written through csr_wr_en/csr_wr_data.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_gesture_latch (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [tbgl_pkg::WINDOW_W-1:0]       csr_wr_data,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [tbgl_pkg::CMD_W-1:0]          req_command,
   input  wire                                 req_which_button,
   input  wire  [tbgl_pkg::KIND_W-1:0]         req_event_kind,
   input  wire  [tbgl_pkg::TIME_W-1:0]         req_time_ms,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [tbgl_pkg::STATE_W-1:0]        rsp_button_state,
   output logic                                rsp_combo_state
);

   logic                       in_valid_ff;
   tbgl_pkg::req_item_type     in_item_ff;
   logic                       rsp_valid_ff;
   tbgl_pkg::rsp_item_type     rsp_item_ff;
   tbgl_pkg::rsp_item_type     rsp_item_in;
   tbgl_pkg::core_status_type  status;
   logic                       advance;

   // process the held request when the output register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.command      <= req_command;
         in_item_ff.which_button <= req_which_button;
         in_item_ff.event_kind   <= req_event_kind;
         in_item_ff.time_ms      <= req_time_ms;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   tbgl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (advance),
      .item        (in_item_ff),
      .result      (rsp_item_in),
      .status      (status)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_state = rsp_item_ff.button_state;
   assign rsp_combo_state  = rsp_item_ff.combo_state;

`ifndef SYNTH
   // a processed request always leaves a response behind
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // the combo flag only rises from an evaluate with both buttons pending
   a_combo_source: assert property (@(posedge clock) disable iff (reset)
      $rose(status.combo_flag) |->
         $past(advance && in_item_ff.command == tbgl_pkg::CMD_EVALUATE &&
               status.left_pending && status.right_pending))
      else $error("combo flag set without a combo evaluate");

   // the request side stalls only when both stages are full and blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request side stalled without back pressure");

   // a held pending left press reads out as idle and stays pending
   a_pending_reads_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.command == tbgl_pkg::CMD_READ_LEFT && status.left_pending)
         |=> (rsp_item_ff.button_state == tbgl_pkg::ST_IDLE && status.left_pending))
      else $error("pending left press was consumed by a read");
`endif

endmodule

`default_nettype wire

FILE: src/tbgl_core.sv
// ----------------------------------------------------------------------------
// tbgl_core: gesture state and per-request update
// Holds both button states, their long-press timestamps, the combo flag and
// the window register; updates them for one request and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbgl_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [tbgl_pkg::WINDOW_W-1:0]       csr_wr_data,
   input  wire                                 item_valid,
   input  wire  tbgl_pkg::req_item_type        item,
   output tbgl_pkg::rsp_item_type              result,
   output tbgl_pkg::core_status_type           status
);

   logic [tbgl_pkg::WINDOW_W-1:0] window_ff;
   logic [tbgl_pkg::STATE_W-1:0]  left_state_ff,  left_state_in;
   logic [tbgl_pkg::STATE_W-1:0]  right_state_ff, right_state_in;
   logic [tbgl_pkg::TIME_W-1:0]   left_time_ff,   left_time_in;
   logic [tbgl_pkg::TIME_W-1:0]   right_time_ff,  right_time_in;
   logic                          combo_ff,       combo_in;

   logic                          left_pend;
   logic                          right_pend;
   logic [tbgl_pkg::TIME_W-1:0]   left_elapsed;
   logic [tbgl_pkg::TIME_W-1:0]   right_elapsed;
   logic [tbgl_pkg::TIME_W-1:0]   window_wide;
   logic                          left_expired;
   logic                          right_expired;
   logic [tbgl_pkg::STATE_W-1:0]  latched_state;
   logic                          event_known;

   assign left_pend     = (left_state_ff == tbgl_pkg::ST_PENDING);
   assign right_pend    = (right_state_ff == tbgl_pkg::ST_PENDING);
   assign window_wide   = {{(tbgl_pkg::TIME_W-tbgl_pkg::WINDOW_W){1'b0}}, window_ff};
   // wrapping subtract: elapsed time modulo 2^32
   assign left_elapsed  = item.time_ms - left_time_ff;
   assign right_elapsed = item.time_ms - right_time_ff;
   assign left_expired  = left_pend && (left_elapsed > window_wide);
   assign right_expired = right_pend && (right_elapsed > window_wide);

   // state an idle button takes on for this event kind
   assign event_known   = (item.event_kind <= tbgl_pkg::EV_LONG);
   assign latched_state = (item.event_kind == tbgl_pkg::EV_LONG) ? tbgl_pkg::ST_PENDING
                                                                 : item.event_kind + 3'd1;

   always_comb begin
      left_state_in       = left_state_ff;
      right_state_in      = right_state_ff;
      left_time_in        = left_time_ff;
      right_time_in       = right_time_ff;
      combo_in            = combo_ff;
      result.button_state = tbgl_pkg::ST_IDLE;
      result.combo_state  = 1'b0;
      case (item.command)
         tbgl_pkg::CMD_EVENT: begin
            if (item.which_button == tbgl_pkg::BTN_LEFT) begin
               if (left_state_ff == tbgl_pkg::ST_IDLE && event_known) begin
                  left_state_in = latched_state;
                  if (item.event_kind == tbgl_pkg::EV_LONG) begin
                     left_time_in = item.time_ms;
                  end
               end
            end else begin
               if (right_state_ff == tbgl_pkg::ST_IDLE && event_known) begin
                  right_state_in = latched_state;
                  if (item.event_kind == tbgl_pkg::EV_LONG) begin
                     right_time_in = item.time_ms;
                  end
               end
            end
         end
         tbgl_pkg::CMD_EVALUATE: begin
            if (left_pend && right_pend) begin
               combo_in       = 1'b1;
               left_state_in  = tbgl_pkg::ST_IDLE;
               right_state_in = tbgl_pkg::ST_IDLE;
            end else if (left_expired) begin
               left_state_in = tbgl_pkg::ST_LONG;
            end else if (right_expired) begin
               right_state_in = tbgl_pkg::ST_LONG;
            end
         end
         tbgl_pkg::CMD_READ_LEFT: begin
            // a pending press reads as idle and stays pending
            if (!left_pend) begin
               result.button_state = left_state_ff;
               left_state_in       = tbgl_pkg::ST_IDLE;
            end
         end
         tbgl_pkg::CMD_READ_RIGHT: begin
            if (!right_pend) begin
               result.button_state = right_state_ff;
               right_state_in      = tbgl_pkg::ST_IDLE;
            end
         end
         tbgl_pkg::CMD_READ_COMBO: begin
            result.combo_state = combo_ff;
            combo_in           = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= tbgl_pkg::WINDOW_RESET;
         left_state_ff  <= tbgl_pkg::ST_IDLE;
         right_state_ff <= tbgl_pkg::ST_IDLE;
         left_time_ff   <= '0;
         right_time_ff  <= '0;
         combo_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         if (item_valid) begin
            left_state_ff  <= left_state_in;
            right_state_ff <= right_state_in;
            left_time_ff   <= left_time_in;
            right_time_ff  <= right_time_in;
            combo_ff       <= combo_in;
         end
      end
   end

   assign status.left_pending  = left_pend;
   assign status.right_pending = right_pend;
   assign status.combo_flag    = combo_ff;

endmodule

`default_nettype wire
